@@ hw/rtl/rti_pkg.sv @@
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types, register-file addresses and the sequencer program of the
// ray-triangle intersection block.
// ----------------------------------------------------------------------------
package rti_pkg;

  typedef logic [5:0] addr_t;

  typedef enum logic [3:0] {
    OP_LDI, OP_ADD, OP_SUB, OP_MUL, OP_CZ, OP_CLT, OP_DIVF,
    OP_SQ0, OP_SQA, OP_SQRT, OP_DIVN, OP_END
  } op_t;

  typedef struct packed {
    op_t   op;
    addr_t ra;
    addr_t rb;
    addr_t rd;
  } uop_t;

  localparam logic [2:0] NUM_SLOTS = 3'd6;
  localparam int NRM_W = 18;
  localparam logic signed [NRM_W-1:0] NRM_ONE = 18'sd65536;

  localparam addr_t V1X = 6'd0,  V1Y = 6'd1,  V1Z = 6'd2;
  localparam addr_t V2X = 6'd3,  V2Y = 6'd4,  V2Z = 6'd5;
  localparam addr_t V3X = 6'd6,  V3Y = 6'd7,  V3Z = 6'd8;
  localparam addr_t N1X = 6'd9,  N1Y = 6'd10, N1Z = 6'd11;
  localparam addr_t N2X = 6'd12, N2Y = 6'd13, N2Z = 6'd14;
  localparam addr_t N3X = 6'd15, N3Y = 6'd16, N3Z = 6'd17;
  localparam addr_t OX = 6'd18, OY = 6'd19, OZ = 6'd20;
  localparam addr_t DX = 6'd21, DY = 6'd22, DZ = 6'd23;
  localparam addr_t TMIN = 6'd24, TMAX = 6'd25;
  localparam addr_t R_A = 6'd26, R_B = 6'd27, R_C = 6'd28;
  localparam addr_t R_D = 6'd29, R_E = 6'd30, R_F = 6'd31;
  localparam addr_t R_J = 6'd32, R_K = 6'd33, R_L = 6'd34;
  localparam addr_t R_P1 = 6'd35, R_P2 = 6'd36;
  localparam addr_t R_EIHF = 6'd37, R_GFDI = 6'd38, R_DHEG = 6'd39;
  localparam addr_t R_AKJB = 6'd40, R_JCAL = 6'd41, R_BLKC = 6'd42;
  localparam addr_t R_DET = 6'd43, R_NUM = 6'd44, R_T = 6'd45;
  localparam addr_t R_BB = 6'd46, R_GG = 6'd47, R_ALPHA = 6'd48;
  localparam addr_t R_PX = 6'd49, R_PY = 6'd50, R_PZ = 6'd51;
  localparam addr_t R_NX = 6'd52, R_NY = 6'd53, R_NZ = 6'd54;
  localparam addr_t R_TMP = 6'd55;
  localparam addr_t K_ZERO = 6'd60, K_ONE = 6'd61, K_NTOL = 6'd62, K_ONETOL = 6'd63;

  localparam addr_t F_OX = 6'd0, F_OY = 6'd1, F_OZ = 6'd2;
  localparam addr_t F_DX = 6'd3, F_DY = 6'd4, F_DZ = 6'd5;
  localparam addr_t F_TMIN = 6'd6, F_TMAX = 6'd7;
  localparam addr_t NRM_X = 6'd0, NRM_Y = 6'd1, NRM_Z = 6'd2;

  localparam int PROG_LEN = 98;

  localparam uop_t PROG [PROG_LEN] = '{
    '{OP_LDI, F_OX, K_ZERO, OX}, '{OP_LDI, F_OY, K_ZERO, OY},
    '{OP_LDI, F_OZ, K_ZERO, OZ}, '{OP_LDI, F_DX, K_ZERO, DX},
    '{OP_LDI, F_DY, K_ZERO, DY}, '{OP_LDI, F_DZ, K_ZERO, DZ},
    '{OP_LDI, F_TMIN, K_ZERO, TMIN}, '{OP_LDI, F_TMAX, K_ZERO, TMAX},
    '{OP_SUB, V1X, V2X, R_A}, '{OP_SUB, V1Y, V2Y, R_B}, '{OP_SUB, V1Z, V2Z, R_C},
    '{OP_SUB, V1X, V3X, R_D}, '{OP_SUB, V1Y, V3Y, R_E}, '{OP_SUB, V1Z, V3Z, R_F},
    '{OP_SUB, V1X, OX, R_J}, '{OP_SUB, V1Y, OY, R_K}, '{OP_SUB, V1Z, OZ, R_L},
    '{OP_MUL, R_E, DZ, R_P1}, '{OP_MUL, DY, R_F, R_P2}, '{OP_SUB, R_P1, R_P2, R_EIHF},
    '{OP_MUL, DX, R_F, R_P1}, '{OP_MUL, R_D, DZ, R_P2}, '{OP_SUB, R_P1, R_P2, R_GFDI},
    '{OP_MUL, R_D, DY, R_P1}, '{OP_MUL, R_E, DX, R_P2}, '{OP_SUB, R_P1, R_P2, R_DHEG},
    '{OP_MUL, R_A, R_EIHF, R_P1}, '{OP_MUL, R_B, R_GFDI, R_P2},
    '{OP_ADD, R_P1, R_P2, R_TMP}, '{OP_MUL, R_C, R_DHEG, R_P1},
    '{OP_ADD, R_TMP, R_P1, R_DET}, '{OP_CZ, R_DET, K_ZERO, R_DET},
    '{OP_MUL, R_A, R_K, R_P1}, '{OP_MUL, R_J, R_B, R_P2}, '{OP_SUB, R_P1, R_P2, R_AKJB},
    '{OP_MUL, R_J, R_C, R_P1}, '{OP_MUL, R_A, R_L, R_P2}, '{OP_SUB, R_P1, R_P2, R_JCAL},
    '{OP_MUL, R_B, R_L, R_P1}, '{OP_MUL, R_K, R_C, R_P2}, '{OP_SUB, R_P1, R_P2, R_BLKC},
    '{OP_MUL, R_F, R_AKJB, R_P1}, '{OP_MUL, R_E, R_JCAL, R_P2},
    '{OP_ADD, R_P1, R_P2, R_TMP}, '{OP_MUL, R_D, R_BLKC, R_P1},
    '{OP_ADD, R_TMP, R_P1, R_NUM},
    '{OP_DIVF, R_NUM, R_DET, R_T}, '{OP_SUB, K_ZERO, R_T, R_T},
    '{OP_CLT, R_T, TMIN, R_T}, '{OP_CLT, TMAX, R_T, R_T},
    '{OP_MUL, R_J, R_EIHF, R_P1}, '{OP_MUL, R_K, R_GFDI, R_P2},
    '{OP_ADD, R_P1, R_P2, R_TMP}, '{OP_MUL, R_L, R_DHEG, R_P1},
    '{OP_ADD, R_TMP, R_P1, R_NUM},
    '{OP_DIVF, R_NUM, R_DET, R_BB}, '{OP_CLT, R_BB, K_NTOL, R_BB},
    '{OP_CLT, K_ONETOL, R_BB, R_BB},
    '{OP_MUL, DZ, R_AKJB, R_P1}, '{OP_MUL, DY, R_JCAL, R_P2},
    '{OP_ADD, R_P1, R_P2, R_TMP}, '{OP_MUL, DX, R_BLKC, R_P1},
    '{OP_ADD, R_TMP, R_P1, R_NUM},
    '{OP_DIVF, R_NUM, R_DET, R_GG}, '{OP_CLT, R_GG, K_NTOL, R_GG},
    '{OP_SUB, K_ONETOL, R_BB, R_TMP}, '{OP_CLT, R_TMP, R_GG, R_GG},
    '{OP_SUB, K_ONE, R_BB, R_TMP}, '{OP_SUB, R_TMP, R_GG, R_ALPHA},
    '{OP_MUL, DX, R_T, R_P1}, '{OP_ADD, R_P1, OX, R_PX},
    '{OP_MUL, DY, R_T, R_P1}, '{OP_ADD, R_P1, OY, R_PY},
    '{OP_MUL, DZ, R_T, R_P1}, '{OP_ADD, R_P1, OZ, R_PZ},
    '{OP_MUL, N1X, R_ALPHA, R_P1}, '{OP_MUL, N2X, R_BB, R_P2},
    '{OP_ADD, R_P1, R_P2, R_TMP}, '{OP_MUL, N3X, R_GG, R_P1},
    '{OP_ADD, R_TMP, R_P1, R_NX},
    '{OP_MUL, N1Y, R_ALPHA, R_P1}, '{OP_MUL, N2Y, R_BB, R_P2},
    '{OP_ADD, R_P1, R_P2, R_TMP}, '{OP_MUL, N3Y, R_GG, R_P1},
    '{OP_ADD, R_TMP, R_P1, R_NY},
    '{OP_MUL, N1Z, R_ALPHA, R_P1}, '{OP_MUL, N2Z, R_BB, R_P2},
    '{OP_ADD, R_P1, R_P2, R_TMP}, '{OP_MUL, N3Z, R_GG, R_P1},
    '{OP_ADD, R_TMP, R_P1, R_NZ},
    '{OP_SQ0, R_NX, K_ZERO, R_NX}, '{OP_SQA, R_NY, K_ZERO, R_NY},
    '{OP_SQA, R_NZ, K_ZERO, R_NZ}, '{OP_SQRT, K_ZERO, K_ZERO, R_TMP},
    '{OP_DIVN, R_NX, K_ZERO, NRM_X}, '{OP_DIVN, R_NY, K_ZERO, NRM_Y},
    '{OP_DIVN, R_NZ, K_ZERO, NRM_Z}, '{OP_END, K_ZERO, K_ZERO, R_TMP}
  };

endpackage

@@ hw/rtl/rti_div.sv @@
// ----------------------------------------------------------------------------
// rti_div
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero.
// ----------------------------------------------------------------------------
module rti_div #(
  parameter int NB = 49,
  parameter int DB = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NB-1:0] num,
  input  logic signed [DB-1:0] den,
  output logic                 done,
  output logic signed [NB:0]   quo
);

  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0] q_r;
  logic [DB-1:0] rem_r;
  logic [DB-1:0] d_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [DB:0]   trial;
  logic          fits;

  assign trial = {rem_r, q_r[NB-1]};
  assign fits  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(NB - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num[NB-1] ? NB'(-num) : NB'(num);
      d_r   <= den[DB-1] ? DB'(-den) : DB'(den);
      neg_r <= num[NB-1] ^ den[DB-1];
      rem_r <= '0;
    end else if (run_r) begin
      rem_r <= fits ? DB'(trial - {1'b0, d_r}) : trial[DB-1:0];
      q_r   <= {q_r[NB-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule

@@ hw/rtl/rti_sqrt.sv @@
// ----------------------------------------------------------------------------
// rti_sqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module rti_sqrt #(
  parameter int RW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*RW-1:0] val,
  output logic            done,
  output logic [RW-1:0]   root
);

  localparam int CW = $clog2(RW + 1);

  logic [2*RW-1:0] rem_r;
  logic [2*RW-1:0] root_r;
  logic [2*RW-1:0] bit_r;
  logic [2*RW-1:0] trial;
  logic [CW-1:0]   cnt_r;
  logic            run_r;
  logic            done_r;

  assign trial = root_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(RW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= val;
      root_r <= '0;
      bit_r  <= {2'b01, {(2*RW-2){1'b0}}};
    end else if (run_r) begin
      if (rem_r >= trial) begin
        rem_r  <= rem_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = root_r[RW-1:0];

endmodule

@@ hw/rtl/ray_triangle_intersect.sv @@
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Ray-triangle intersection by Cramer's rule in signed fixed point, run as a
// microprogram over one register file, one multiply/add unit, an iterative
// divider and an iterative square root.
// ----------------------------------------------------------------------------
// A load item is the transfer followed by three register-file writes.
// A ray item takes each of its 98 micro-ops through a read and an execute
// state and waits in the wait state for each of up to six divisions and for
// the square root; it ends early when the ray is rejected. The register
// file, with its one write port, and the shared divider set the run time.
// Synchronous reset clears the sequencer and the material; stored vectors
// are undefined until loaded. Results cannot be stalled.
module ray_triangle_intersect import rti_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_action,
  input  logic [2:0]              in_slot,
  input  logic signed [31:0]      in_vec_x,
  input  logic signed [31:0]      in_vec_y,
  input  logic signed [31:0]      in_vec_z,
  input  logic signed [31:0]      in_dir_x,
  input  logic signed [31:0]      in_dir_y,
  input  logic signed [31:0]      in_dir_z,
  input  logic signed [31:0]      in_t_min,
  input  logic signed [31:0]      in_t_max,
  input  logic [7:0]              in_material_in,
  output logic                    out_valid,
  output logic                    out_hit,
  output logic signed [31:0]      out_t_hit,
  output logic signed [31:0]      out_point_x,
  output logic signed [31:0]      out_point_y,
  output logic signed [31:0]      out_point_z,
  output logic signed [NRM_W-1:0] out_normal_x,
  output logic signed [NRM_W-1:0] out_normal_y,
  output logic signed [NRM_W-1:0] out_normal_z,
  output logic [7:0]              out_material_out
);

  localparam int AW  = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);
  localparam int OW  = (AW > FRAC_BITS + 2) ? AW : FRAC_BITS + 2;
  localparam int NSH = (FRAC_BITS > 16) ? FRAC_BITS : 16;
  localparam int NB  = AW + NSH + 1;
  localparam int DB  = AW + 1;
  localparam int XW  = ((2 * OW > NB + 1) ? 2 * OW : NB + 1) + 1;
  localparam int PCW = $clog2(PROG_LEN);

  localparam longint ONE_I = 64'sd1 <<< FRAC_BITS;
  localparam longint TOL_I = (ONE_I + 5000) / 10000;
  localparam logic signed [OW-1:0] ONE_C    = OW'(ONE_I);
  localparam logic signed [OW-1:0] NTOL_C   = OW'(-TOL_I);
  localparam logic signed [OW-1:0] ONETOL_C = OW'(ONE_I + TOL_I);
  localparam logic signed [XW-1:0] MAX_X = {{(XW-AW+1){1'b0}}, {(AW-1){1'b1}}};
  localparam logic signed [XW-1:0] MIN_X = {{(XW-AW+1){1'b1}}, {(AW-1){1'b0}}};

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_RD   = 5'b00100,
    S_EX   = 5'b01000,
    S_WAIT = 5'b10000
  } state_t;

  function automatic logic signed [AW-1:0] sat_x(input logic signed [XW-1:0] v);
    if (v > MAX_X) return MAX_X[AW-1:0];
    if (v < MIN_X) return MIN_X[AW-1:0];
    return v[AW-1:0];
  endfunction

  state_t            state_r, state_nxt;
  logic [PCW-1:0]    pc_r, pc_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [7:0]        material_r;
  logic [2:0]        slot_r;
  logic [31:0]       lat_r [8];
  uop_t              uop;

  logic signed [AW-1:0] rf [64];
  logic signed [AW-1:0] rd_a_q, rd_b_q;
  addr_t                ra_r, rb_r;
  logic signed [OW-1:0] opa, opb, mul_b;
  logic signed [2*OW-1:0] prod;
  logic signed [XW-1:0] sum_x, dif_x, mul_x;

  logic [2:0]           fsel;
  logic signed [AW-1:0] fld;
  logic                 we;
  addr_t                wa;
  logic signed [AW-1:0] wd;

  logic                 miss, hit_e, adv, to_wait;
  logic                 div_start, div_done, sqrt_start, sqrt_done;
  logic signed [NB-1:0] div_num;
  logic signed [DB-1:0] div_den;
  logic signed [NB:0]   quo;
  logic [2*AW-1:0]      acc_r;
  logic [AW-1:0]        len_r, root;
  logic signed [NRM_W-1:0] nrm_q;
  logic signed [AW-1:0] t_r;
  logic signed [AW-1:0] pt_r [3];
  logic signed [NRM_W-1:0] nrm_r [3];
  logic                 out_valid_r;

  assign uop  = PROG[pc_r];
  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    rd_a_q <= rf[uop.ra];
    rd_b_q <= rf[uop.rb];
    ra_r   <= uop.ra;
    rb_r   <= uop.rb;
    if (we) begin
      rf[wa] <= wd;
    end
  end

  always_comb begin
    case (ra_r)
      K_ZERO:   opa = '0;
      K_ONE:    opa = ONE_C;
      K_NTOL:   opa = NTOL_C;
      K_ONETOL: opa = ONETOL_C;
      default:  opa = OW'(rd_a_q);
    endcase
    case (rb_r)
      K_ZERO:   opb = '0;
      K_ONE:    opb = ONE_C;
      K_NTOL:   opb = NTOL_C;
      K_ONETOL: opb = ONETOL_C;
      default:  opb = OW'(rd_b_q);
    endcase
  end

  assign mul_b = (uop.op == OP_SQ0 || uop.op == OP_SQA) ? opa : opb;
  assign prod  = opa * mul_b;
  assign sum_x = XW'(opa) + XW'(opb);
  assign dif_x = XW'(opa) - XW'(opb);
  assign mul_x = XW'(prod) >>> FRAC_BITS;

  assign fsel = (state_r == S_LOAD) ? {1'b0, cnt_r} : uop.ra[2:0];
  assign fld  = sat_x(XW'($signed(lat_r[fsel])));

  always_comb begin
    we = 1'b0;
    wa = uop.rd;
    wd = fld;
    if (state_r == S_LOAD) begin
      we = slot_r < NUM_SLOTS;
      wa = addr_t'(slot_r) * addr_t'(3) + addr_t'(cnt_r);
    end else if (state_r == S_EX) begin
      case (uop.op)
        OP_LDI: we = 1'b1;
        OP_ADD: begin
          we = 1'b1;
          wd = sat_x(sum_x);
        end
        OP_SUB: begin
          we = 1'b1;
          wd = sat_x(dif_x);
        end
        OP_MUL: begin
          we = 1'b1;
          wd = sat_x(mul_x);
        end
        default: we = 1'b0;
      endcase
    end else if (state_r == S_WAIT && uop.op == OP_DIVF && div_done) begin
      we = 1'b1;
      wd = sat_x(XW'(quo));
    end
  end

  assign div_start  = (state_r == S_EX) &&
                      (uop.op == OP_DIVF || (uop.op == OP_DIVN && len_r != '0));
  assign sqrt_start = (state_r == S_EX) && (uop.op == OP_SQRT);
  assign div_num    = (uop.op == OP_DIVN) ? (NB'(opa) <<< 16) : (NB'(opa) <<< FRAC_BITS);
  assign div_den    = (uop.op == OP_DIVN) ? DB'({1'b0, len_r}) : DB'(opb);

  rti_div #(.NB(NB), .DB(DB)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  rti_sqrt #(.RW(AW)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .val   (acc_r),
    .done  (sqrt_done),
    .root  (root)
  );

  always_comb begin
    if (quo > (NB+1)'(NRM_ONE)) begin
      nrm_q = NRM_ONE;
    end else if (quo < -(NB+1)'(NRM_ONE)) begin
      nrm_q = -NRM_ONE;
    end else begin
      nrm_q = quo[NRM_W-1:0];
    end
  end

  always_comb begin
    miss    = 1'b0;
    hit_e   = 1'b0;
    adv     = 1'b0;
    to_wait = 1'b0;
    if (state_r == S_EX) begin
      case (uop.op) inside
        OP_LDI, OP_ADD, OP_SUB, OP_MUL, OP_SQ0, OP_SQA: adv = 1'b1;
        OP_CZ: begin
          miss = (opa == '0);
          adv  = !miss;
        end
        OP_CLT: begin
          miss = (opa < opb);
          adv  = !miss;
        end
        OP_DIVF, OP_SQRT: to_wait = 1'b1;
        OP_DIVN: begin
          to_wait = (len_r != '0);
          adv     = (len_r == '0);
        end
        OP_END: hit_e = 1'b1;
        default: adv = 1'b1;
      endcase
    end else if (state_r == S_WAIT) begin
      adv = div_done || sqrt_done;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = in_action ? S_RD : S_LOAD;
          pc_nxt    = '0;
          cnt_nxt   = '0;
        end
      end
      S_LOAD: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd2) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD: state_nxt = S_EX;
      S_EX: begin
        if (miss || hit_e) begin
          state_nxt = S_IDLE;
        end else if (to_wait) begin
          state_nxt = S_WAIT;
        end else if (adv) begin
          state_nxt = S_RD;
          pc_nxt    = pc_r + PCW'(1);
        end
      end
      S_WAIT: begin
        if (adv) begin
          state_nxt = S_RD;
          pc_nxt    = pc_r + PCW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      cnt_r       <= '0;
      material_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= miss || hit_e;
      if (state_r == S_IDLE && start && !in_action) begin
        material_r <= in_material_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      slot_r   <= in_slot;
      lat_r[0] <= in_vec_x;
      lat_r[1] <= in_vec_y;
      lat_r[2] <= in_vec_z;
      lat_r[3] <= in_dir_x;
      lat_r[4] <= in_dir_y;
      lat_r[5] <= in_dir_z;
      lat_r[6] <= in_t_min;
      lat_r[7] <= in_t_max;
    end
    if (we && wa == R_T)  t_r      <= wd;
    if (we && wa == R_PX) pt_r[0]  <= wd;
    if (we && wa == R_PY) pt_r[1]  <= wd;
    if (we && wa == R_PZ) pt_r[2]  <= wd;
    if (state_r == S_EX && uop.op == OP_SQ0) acc_r <= prod[2*AW-1:0];
    if (state_r == S_EX && uop.op == OP_SQA) acc_r <= acc_r + prod[2*AW-1:0];
    if (sqrt_done) len_r <= root;
    if (uop.op == OP_DIVN && state_r == S_EX && len_r == '0) begin
      nrm_r[uop.rd[1:0]] <= '0;
    end
    if (uop.op == OP_DIVN && state_r == S_WAIT && div_done) begin
      nrm_r[uop.rd[1:0]] <= nrm_q;
    end
    if (hit_e) begin
      out_hit          <= 1'b1;
      out_t_hit        <= 32'(t_r);
      out_point_x      <= 32'(pt_r[0]);
      out_point_y      <= 32'(pt_r[1]);
      out_point_z      <= 32'(pt_r[2]);
      out_normal_x     <= nrm_r[0];
      out_normal_y     <= nrm_r[1];
      out_normal_z     <= nrm_r[2];
      out_material_out <= material_r;
    end else if (miss) begin
      out_hit          <= 1'b0;
      out_t_hit        <= '0;
      out_point_x      <= '0;
      out_point_y      <= '0;
      out_point_z      <= '0;
      out_normal_x     <= '0;
      out_normal_y     <= '0;
      out_normal_z     <= '0;
      out_material_out <= '0;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("Accepted transfer did not make the block busy.");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Result strobe held for more than one cycle.");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("Result presented while the sequencer is still running.");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_t_hit == '0 && out_material_out == '0))
    else $error("Miss result carries nonzero fields.");

endmodule

@@ tb/sv/ray_triangle_intersect_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect_tb
// Self-checking testbench for the fixed-point ray-triangle intersection block.
// A scoreboard predicts every ray result from its own copy of the stored
// triangle and checks each strobed result in order. A directed part covers
// the corner cases; most random traffic is triangle loads with rays aimed at them.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_tb;
  import rti_pkg::*;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RAY  = 1'b1;
  localparam longint Q_ONE = 65536;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam longint BARY_TOL = (Q_ONE + 5000) / 10000;
  localparam int LIMIT_CYCLES = 3000000;

  typedef struct {
    logic              action;
    logic [2:0]        slot;
    logic signed [31:0] vec [3];
    logic signed [31:0] dir [3];
    logic signed [31:0] t_lo;
    logic signed [31:0] t_hi;
    logic [7:0]        material;
  } item_t;

  typedef struct {
    logic                     hit;
    logic signed [31:0]       t_hit;
    logic signed [31:0]       point [3];
    logic signed [NRM_W-1:0]  normal [3];
    logic [7:0]               material;
  } hit_t;

  class IntersectChecker;
    longint tri_vec [18];
    logic [7:0] tri_material;
    hit_t expected_hits [$];
    int mismatches;
    int rays;
    int hits;
    int loads;

    function new();
      foreach (tri_vec[n]) tri_vec[n] = 0;
      tri_material = 0;
      mismatches = 0;
      rays = 0;
      hits = 0;
      loads = 0;
    endfunction

    function longint sat_q(longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
    endfunction

    function longint mul_q(longint x, longint y);
      longint p;
      p = x * y;
      return sat_q(p >>> 16);
    endfunction

    function longint div_q(longint n, longint m);
      return sat_q((n * Q_ONE) / m);
    endfunction

    function longint dot_q(longint a, longint x, longint b, longint y, longint c, longint z);
      return sat_q(sat_q(mul_q(a, x) + mul_q(b, y)) + mul_q(c, z));
    endfunction

    function longint unsigned root64(longint unsigned v);
      longint unsigned rem = v;
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (rem >= r + b) begin
          rem = rem - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function hit_t solve_ray(item_t it);
      hit_t res;
      longint o [3];
      longint dv [3];
      longint nrm [3];
      longint a, b, c, d, e, f, g, h, i, j, k, l;
      longint eihf, gfdi, dheg, akjb, jcal, blkc, det, t, bb, gg, alpha, un;
      longint unsigned sq, len;
      res.hit = 0;
      res.t_hit = 0;
      res.material = 0;
      for (int ax = 0; ax < 3; ax++) begin
        res.point[ax] = 0;
        res.normal[ax] = 0;
        o[ax] = longint'(it.vec[ax]);
        dv[ax] = longint'(it.dir[ax]);
      end
      a = sat_q(tri_vec[0] - tri_vec[3]);
      b = sat_q(tri_vec[1] - tri_vec[4]);
      c = sat_q(tri_vec[2] - tri_vec[5]);
      d = sat_q(tri_vec[0] - tri_vec[6]);
      e = sat_q(tri_vec[1] - tri_vec[7]);
      f = sat_q(tri_vec[2] - tri_vec[8]);
      g = dv[0];
      h = dv[1];
      i = dv[2];
      j = sat_q(tri_vec[0] - o[0]);
      k = sat_q(tri_vec[1] - o[1]);
      l = sat_q(tri_vec[2] - o[2]);
      eihf = sat_q(mul_q(e, i) - mul_q(h, f));
      gfdi = sat_q(mul_q(g, f) - mul_q(d, i));
      dheg = sat_q(mul_q(d, h) - mul_q(e, g));
      det = dot_q(a, eihf, b, gfdi, c, dheg);
      if (det == 0) return res;
      akjb = sat_q(mul_q(a, k) - mul_q(j, b));
      jcal = sat_q(mul_q(j, c) - mul_q(a, l));
      blkc = sat_q(mul_q(b, l) - mul_q(k, c));
      t = sat_q(-div_q(dot_q(f, akjb, e, jcal, d, blkc), det));
      if (t < longint'(it.t_lo) || t > longint'(it.t_hi)) return res;
      bb = div_q(dot_q(j, eihf, k, gfdi, l, dheg), det);
      if (bb < -BARY_TOL || bb > Q_ONE + BARY_TOL) return res;
      gg = div_q(dot_q(i, akjb, h, jcal, g, blkc), det);
      if (gg < -BARY_TOL || gg > sat_q(Q_ONE + BARY_TOL - bb)) return res;
      alpha = sat_q(sat_q(Q_ONE - bb) - gg);
      sq = 0;
      for (int ax = 0; ax < 3; ax++) begin
        res.point[ax] = 32'(sat_q(mul_q(dv[ax], t) + o[ax]));
        nrm[ax] = dot_q(tri_vec[9 + ax], alpha, tri_vec[12 + ax], bb, tri_vec[15 + ax], gg);
        sq += longint'(nrm[ax] * nrm[ax]);
      end
      len = root64(sq);
      for (int ax = 0; ax < 3; ax++) begin
        un = 0;
        if (len != 0) begin
          un = (nrm[ax] * Q_ONE) / longint'(len);
          if (un > Q_ONE) un = Q_ONE;
          if (un < -Q_ONE) un = -Q_ONE;
        end
        res.normal[ax] = un[NRM_W-1:0];
      end
      res.hit = 1;
      res.t_hit = t[31:0];
      res.material = tri_material;
      return res;
    endfunction

    function void note_transfer(item_t it);
      if (it.action == ACT_LOAD) begin
        loads++;
        if (it.slot < NUM_SLOTS)
          for (int ax = 0; ax < 3; ax++) tri_vec[it.slot * 3 + ax] = longint'(it.vec[ax]);
        tri_material = it.material;
      end else begin
        rays++;
        expected_hits.push_back(solve_ray(it));
      end
    endfunction

    function void compare(string field, longint want, longint got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: %s expected %0d, got %0d", rays - expected_hits.size(),
                   field, want, got);
      end
    endfunction

    function void check_result(hit_t got);
      hit_t want;
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result strobed with no ray outstanding.");
        return;
      end
      want = expected_hits.pop_front();
      if (want.hit) hits++;
      compare("hit", want.hit, got.hit);
      compare("t_hit", want.t_hit, got.t_hit);
      for (int ax = 0; ax < 3; ax++) begin
        compare($sformatf("point[%0d]", ax), want.point[ax], got.point[ax]);
        compare($sformatf("normal[%0d]", ax), want.normal[ax], got.normal[ax]);
      end
      compare("material", want.material, got.material);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_action;
  logic [2:0] in_slot;
  logic signed [31:0] in_vec_x, in_vec_y, in_vec_z;
  logic signed [31:0] in_dir_x, in_dir_y, in_dir_z;
  logic signed [31:0] in_t_min, in_t_max;
  logic [7:0] in_material_in;
  logic out_valid;
  logic out_hit;
  logic signed [31:0] out_t_hit, out_point_x, out_point_y, out_point_z;
  logic signed [NRM_W-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic [7:0] out_material_out;

  IntersectChecker sb = new();
  bit gaps_on;
  int cycles = 0;

  ray_triangle_intersect i_dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    item_t it;
    hit_t res;
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("ray_triangle_intersect: mismatch");
      $finish;
    end
    if (rst_n && start && !busy) begin
      it.action = in_action;
      it.slot = in_slot;
      it.vec[0] = in_vec_x;
      it.vec[1] = in_vec_y;
      it.vec[2] = in_vec_z;
      it.dir[0] = in_dir_x;
      it.dir[1] = in_dir_y;
      it.dir[2] = in_dir_z;
      it.t_lo = in_t_min;
      it.t_hi = in_t_max;
      it.material = in_material_in;
      sb.note_transfer(it);
    end
    if (rst_n && out_valid) begin
      res.hit = out_hit;
      res.t_hit = out_t_hit;
      res.point[0] = out_point_x;
      res.point[1] = out_point_y;
      res.point[2] = out_point_z;
      res.normal[0] = out_normal_x;
      res.normal[1] = out_normal_y;
      res.normal[2] = out_normal_z;
      res.material = out_material_out;
      sb.check_result(res);
    end
  end

  task automatic send(item_t it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= it.action;
    in_slot <= it.slot;
    in_vec_x <= it.vec[0];
    in_vec_y <= it.vec[1];
    in_vec_z <= it.vec[2];
    in_dir_x <= it.dir[0];
    in_dir_y <= it.dir[1];
    in_dir_z <= it.dir[2];
    in_t_min <= it.t_lo;
    in_t_max <= it.t_hi;
    in_material_in <= it.material;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic signed [31:0] coord(int span);
    return $signed($urandom_range(0, 2 * span * 65536)) - span * 65536;
  endfunction

  function automatic item_t noise_item();
    item_t it;
    it.action = 1'($urandom_range(0, 1));
    it.slot = 3'($urandom_range(0, 7));
    for (int ax = 0; ax < 3; ax++) begin
      it.vec[ax] = $urandom;
      it.dir[ax] = $urandom;
    end
    it.t_lo = $urandom;
    it.t_hi = $urandom;
    it.material = 8'($urandom);
    return it;
  endfunction

  function automatic item_t load_item(logic [2:0] slot, logic signed [31:0] x,
                                      logic signed [31:0] y, logic signed [31:0] z);
    item_t it;
    it = noise_item();
    it.action = ACT_LOAD;
    it.slot = slot;
    it.vec[0] = x;
    it.vec[1] = y;
    it.vec[2] = z;
    return it;
  endfunction

  // A ray from a random origin toward a barycentric point of the stored
  // triangle, so that t is close to one.
  function automatic item_t aimed_ray(logic signed [31:0] v [9]);
    item_t it;
    longint wb, wg, tgt;
    it = noise_item();
    it.action = ACT_RAY;
    wb = longint'($urandom_range(0, 70000)) - 3000;
    wg = longint'($urandom_range(0, 70000)) - 3000;
    for (int ax = 0; ax < 3; ax++) begin
      tgt = longint'(v[ax]) + ((longint'(v[3 + ax]) - v[ax]) * wb >>> 16)
            + ((longint'(v[6 + ax]) - v[ax]) * wg >>> 16);
      it.vec[ax] = coord(20);
      it.dir[ax] = 32'(tgt - it.vec[ax]);
    end
    it.t_lo = ($urandom_range(0, 7) == 0) ? coord(2) : -32'sd65536;
    it.t_hi = ($urandom_range(0, 7) == 0) ? coord(2) : 32'sd4 * 65536;
    return it;
  endfunction

  task automatic triangle_burst(int rays_wanted);
    logic signed [31:0] v [9];
    bit flat_normals;
    flat_normals = ($urandom_range(0, 9) == 0);
    for (int n = 0; n < 9; n++) v[n] = coord(16);
    if ($urandom_range(0, 19) == 0) for (int n = 3; n < 9; n++) v[n] = v[n % 3];
    for (int s = 0; s < 3; s++) send(load_item(3'(s), v[3*s], v[3*s+1], v[3*s+2]));
    for (int s = 3; s < 6; s++)
      send(flat_normals ? load_item(3'(s), 0, 0, 0)
                        : load_item(3'(s), coord(2), coord(2), coord(2)));
    for (int r = 0; r < rays_wanted; r++)
      send(($urandom_range(0, 9) == 0) ? noise_item() : aimed_ray(v));
  endtask

  task automatic drain();
    @(posedge clk);
    while (sb.expected_hits.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  initial begin
    item_t it;
    logic signed [31:0] tri_pts [9];
    int sent;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_action <= ACT_LOAD;
    in_slot <= '0;
    in_vec_x <= '0;
    in_vec_y <= '0;
    in_vec_z <= '0;
    in_dir_x <= '0;
    in_dir_y <= '0;
    in_dir_z <= '0;
    in_t_min <= '0;
    in_t_max <= '0;
    in_material_in <= '0;
    gaps_on = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, unused slots, hit, window miss, degenerate, zero normal.
    tri_pts = '{0, 0, 0, 32'sd65536, 0, 0, 0, 32'sd65536, 0};
    send(load_item(3'd0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff));
    for (int s = 0; s < 3; s++)
      send(load_item(3'(s), tri_pts[3*s], tri_pts[3*s+1], tri_pts[3*s+2]));
    send(load_item(3'd3, 0, 0, 32'sd65536));
    send(load_item(3'd4, 32'h7fff_ffff, 32'h8000_0000, 32'sd65536));
    send(load_item(3'd5, 0, 32'sd65536, 0));
    it = load_item(3'd6, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    it.material = 8'hff;
    send(it);
    it = load_item(3'd7, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    it.material = 8'h00;
    send(it);
    send(aimed_ray(tri_pts));
    it = aimed_ray(tri_pts);
    it.t_lo = 32'sd65536 * 5;
    send(it);
    it = aimed_ray(tri_pts);
    it.t_lo = 32'h7fff_ffff;
    it.t_hi = 32'h8000_0000;
    send(it);
    it = noise_item();
    it.action = ACT_RAY;
    for (int ax = 0; ax < 3; ax++) begin
      it.vec[ax] = 32'h8000_0000;
      it.dir[ax] = 32'h7fff_ffff;
    end
    it.t_lo = 32'h8000_0000;
    it.t_hi = 32'h7fff_ffff;
    send(it);
    for (int s = 3; s < 6; s++) send(load_item(3'(s), 0, 0, 0));
    send(aimed_ray(tri_pts));
    for (int s = 0; s < 3; s++) send(load_item(3'(s), 32'sd65536, 32'sd65536, 32'sd65536));
    send(aimed_ray(tri_pts));

    gaps_on = 1;
    sent = 0;
    while (sent < 1800) begin
      if (sent >= 1500) gaps_on = 0;
      if (sent >= 700 && sent < 720) begin
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_hits.size() != 0) @(posedge clk);
        sent = 720;
      end
      if ($urandom_range(0, 5) == 0) begin
        send(noise_item());
        sent++;
      end else begin
        int r;
        r = $urandom_range(1, 6);
        triangle_burst(r);
        sent += 6 + r;
      end
    end
    start <= 1'b0;
    drain();

    $display("Covered %0d loads and %0d rays, %0d of which hit the triangle.",
             sb.loads, sb.rays, sb.hits);
    if (sb.mismatches == 0 && sb.expected_hits.size() == 0) begin
      $display("ray_triangle_intersect: match");
    end else begin
      $display("%0d mismatches, %0d results missing.", sb.mismatches, sb.expected_hits.size());
      $display("ray_triangle_intersect: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/rti_pkg.sv
hw/rtl/rti_div.sv
hw/rtl/rti_sqrt.sv
hw/rtl/ray_triangle_intersect.sv
tb/sv/ray_triangle_intersect_tb.sv
